// ===== hdl/kms_pkg.sv =====
// ============================================================================
// kms_pkg
// Shared types and constants of the k-mer MinHash sketch.
// ============================================================================
package kms_pkg;

    localparam int LOG_DEPTH    = 12;
    localparam int MAX_FP_WIDTH = 16;
    localparam int DEPTH        = 1 << LOG_DEPTH;
    localparam int FPW          = MAX_FP_WIDTH;
    localparam int EMW          = LOG_DEPTH + 1;

    localparam logic [63:0] MIX_FWD = 64'hD6E8FEB86659FD93;
    localparam logic [63:0] MIX_INV = 64'hCFEE444D8B59A89B;

    localparam logic [1:0] CMD_BASE   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_KMER_LEN    = 2'd0;
    localparam logic [1:0] REG_LOG_BUCKETS = 2'd1;
    localparam logic [1:0] REG_FP_BITS     = 2'd2;
    localparam logic [1:0] REG_LZ_BITS     = 2'd3;

    // Operations issued by the controller to the datapath.
    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_MUL   = 4'd2,
        OP_XOR   = 4'd3,
        OP_FIN   = 4'd4,
        OP_RMW_R = 4'd5,
        OP_RMW_W = 4'd6,
        OP_READ  = 4'd7,
        OP_CLR   = 4'd8,
        OP_OUT   = 4'd9
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] part;     // partial product index, 0..2
        logic       sel_inv;  // 1: bucket hash, 0: fingerprint hash
    } t_cmd;

    typedef struct packed {
        logic hash_ok;   // the k-mer is complete, a hash is needed
        logic clr_done;  // the clearing sweep reached its last entry
    } t_stat;

endpackage

// ===== hdl/kms_datapath.sv =====
// ============================================================================
// kms_datapath
// K-mer registers, a shared 32x32 multiplier, fingerprint logic and the store.
// ============================================================================
module kms_datapath
    import kms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [7:0]           i_base_char,
    input  logic                 i_seq_start,
    input  logic [11:0]          i_bucket_index,
    input  logic [4:0]           i_kmer_len,
    input  logic [3:0]           i_log_buckets,
    input  logic [4:0]           i_fp_bits,
    input  logic [2:0]           i_lz_bits,
    output logic [16:0]          o_bucket_value,
    output logic [EMW-1:0]       o_empty_count
);

    logic [61:0]          r_fwd, r_rev;
    logic [4:0]           r_seen;
    logic [EMW-1:0]       r_empty;
    logic [63:0]          r_canon, r_x, r_acc, r_hb, r_hf;
    logic [LOG_DEPTH-1:0] r_addr;
    logic [LOG_DEPTH-1:0] r_clr_addr;
    logic [FPW-1:0]       r_fp;
    logic [FPW:0]         r_rd;
    // The top bit of an entry marks the bucket as empty.
    logic [FPW:0]         mem [DEPTH];
    logic                 r_vrd;
    logic [16:0]          r_out;

    logic [4:0]           k;
    logic [3:0]           lb;
    logic [63:0]          mask, fwd_n, rev_n, c, xm, pp, hf;
    logic [1:0]           fc, rc;
    logic [4:0]           seen_n;
    logic [31:0]          ma, mb;
    logic [6:0]           lzc;
    logic [4:0]           w, hz, m;
    logic [6:0]           maxrem, rem;
    logic [FPW-1:0]       fp_n;
    logic [LOG_DEPTH-1:0] bkt;

    assign k  = (i_kmer_len < 5'd2) ? 5'd2 : i_kmer_len;
    assign lb = (i_log_buckets > 4'(LOG_DEPTH)) ? 4'(LOG_DEPTH) : i_log_buckets;
    assign mask = (64'd1 << {k, 1'b0}) - 64'd1;
    assign c = i_cmd.sel_inv ? MIX_INV : MIX_FWD;

    always_comb begin
        case (i_base_char)
            8'h43:   begin fc = 2'd1; rc = 2'd2; end
            8'h47:   begin fc = 2'd2; rc = 2'd1; end
            8'h54:   begin fc = 2'd3; rc = 2'd0; end
            8'h41:   begin fc = 2'd0; rc = 2'd3; end
            default: begin fc = 2'd0; rc = 2'd0; end
        endcase
    end

    always_comb begin
        fwd_n  = i_seq_start ? 64'd0 : {2'b0, r_fwd};
        rev_n  = i_seq_start ? 64'd0 : {2'b0, r_rev};
        seen_n = i_seq_start ? 5'd0 : r_seen;
        fwd_n  = ((fwd_n << 2) | {62'd0, fc}) & mask;
        rev_n  = ((rev_n & mask) >> 2) | ({62'd0, rc} << ({k, 1'b0} - 6'd2));
        if (seen_n != 5'd31) seen_n = seen_n + 5'd1;
    end

    // Three 32x32 partial products of x * c, low 64 bits only.
    always_comb begin
        case (i_cmd.part)
            2'd0:    begin ma = r_x[31:0];  mb = c[31:0];  end
            2'd1:    begin ma = r_x[31:0];  mb = c[63:32]; end
            default: begin ma = r_x[63:32]; mb = c[31:0];  end
        endcase
        pp = 64'(ma) * 64'(mb);
        if (i_cmd.part != 2'd0) pp = {pp[31:0], 32'd0};
    end

    assign xm = (r_acc >> 32) ^ r_acc;
    assign hf = r_hf;

    always_comb begin
        lzc = 7'd64;
        for (int i = 0; i < 64; i++) if (hf[i]) lzc = 7'(63 - i);
        w  = (i_fp_bits > 5'(MAX_FP_WIDTH)) ? 5'(MAX_FP_WIDTH) : i_fp_bits;
        hz = ({2'b0, i_lz_bits} > w) ? w : {2'b0, i_lz_bits};
        m  = w - hz;
        maxrem = (7'd1 << hz) - 7'd1;
        rem = (maxrem > lzc) ? maxrem - lzc : 7'd0;
        fp_n = FPW'((hf & ((64'd1 << m) - 64'd1)) + ({57'd0, rem} << m));
    end

    assign bkt = (lb == 4'd0) ? '0 : LOG_DEPTH'(r_hb >> (7'd64 - {3'd0, lb}));

    assign o_stat.hash_ok  = (seen_n >= k);
    assign o_stat.clr_done = (r_clr_addr == LOG_DEPTH'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= '0;
            r_rev      <= '0;
            r_seen     <= '0;
            r_clr_addr <= '0;
            r_empty    <= EMW'(1) << 4'd10;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_fwd   <= fwd_n[61:0];
                    r_rev   <= rev_n[61:0];
                    r_seen  <= seen_n;
                    r_canon <= (fwd_n < rev_n) ? fwd_n : rev_n;
                    r_x     <= (((fwd_n < rev_n) ? fwd_n : rev_n) >> 32)
                               ^ ((fwd_n < rev_n) ? fwd_n : rev_n);
                    r_acc   <= '0;
                end
                OP_MUL: r_acc <= r_acc + pp;
                OP_XOR: begin
                    r_x   <= xm;
                    r_acc <= '0;
                end
                OP_FIN: begin
                    if (i_cmd.sel_inv) begin
                        r_hb <= xm;
                        r_x  <= (r_canon >> 32) ^ r_canon;
                    end else begin
                        r_hf <= xm;
                    end
                    r_acc <= '0;
                end
                OP_RMW_R: begin
                    r_addr <= bkt;
                    r_fp   <= fp_n;
                    r_rd   <= mem[bkt];
                    r_vrd  <= !mem[bkt][FPW];
                end
                OP_RMW_W: begin
                    if (!r_vrd) begin
                        if (r_empty != '0) r_empty <= r_empty - EMW'(1);
                    end
                end
                OP_READ: begin
                    r_rd  <= mem[i_bucket_index[LOG_DEPTH-1:0]];
                    r_vrd <= !mem[i_bucket_index[LOG_DEPTH-1:0]][FPW];
                end
                OP_CLR: begin
                    // The sweep visits one entry per cycle and wraps back to zero.
                    r_clr_addr <= r_clr_addr + LOG_DEPTH'(1);
                    if (r_clr_addr == '0) r_empty <= EMW'(1) << lb;
                end
                OP_OUT: r_out <= r_vrd ? 17'(r_rd) : 17'h1FFFF;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLR)
            mem[r_clr_addr] <= {1'b1, {FPW{1'b0}}};
        else if (i_cmd.op == OP_RMW_W && (!r_vrd || r_rd[FPW-1:0] > r_fp))
            mem[r_addr] <= {1'b0, r_fp};
    end

    assign o_bucket_value = r_out;
    assign o_empty_count  = r_empty;

endmodule

// ===== hdl/kms_ctrl.sv =====
// ============================================================================
// kms_ctrl
// Sequencer that steps the datapath through hashing, update, read and clear.
// ============================================================================
module kms_ctrl
    import kms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_fire,
    input  logic [1:0] i_in_cmd,
    input  t_stat      i_stat,
    output logic       o_busy,
    output logic       o_out_load,
    input  logic       i_out_free,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_XOR  = 8'b00000100,
        S_UPD  = 8'b00001000,
        S_WR   = 8'b00010000,
        S_RD   = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_CLR  = 8'b10000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_part, n_part;
    logic       r_round, n_round;
    logic       r_hash, n_hash;

    always_comb begin
        n_state = r_state;
        n_part  = r_part;
        n_round = r_round;
        n_hash  = r_hash;
        o_cmd   = '{op: OP_IDLE, part: r_part, sel_inv: ~r_hash};
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    case (i_in_cmd)
                        CMD_BASE: begin
                            o_cmd.op = OP_LOAD;
                            if (i_stat.hash_ok) begin
                                n_state = S_MUL;
                                n_part  = 2'd0;
                                n_round = 1'b0;
                                n_hash  = 1'b0;
                            end
                        end
                        CMD_READ: begin
                            o_cmd.op = OP_READ;
                            n_state  = S_RD;
                        end
                        CMD_CLEAR: begin
                            o_cmd.op = OP_CLR;
                            n_state  = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_part = r_part + 2'd1;
                if (r_part == 2'd2) begin
                    n_part  = 2'd0;
                    n_state = S_XOR;
                end
            end
            S_XOR: begin
                o_cmd.op = r_round ? OP_FIN : OP_XOR;
                n_round  = ~r_round;
                n_state  = S_MUL;
                if (r_round) begin
                    n_hash = 1'b1;
                    if (r_hash) n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.op = OP_RMW_R;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.op = OP_RMW_W;
                n_state  = S_IDLE;
            end
            S_RD: begin
                if (i_out_free) begin
                    o_cmd.op   = OP_OUT;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                o_out_load = 1'b1;
                n_state    = S_IDLE;
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_part  <= '0;
            r_round <= 1'b0;
            r_hash  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_round <= n_round;
            r_hash  <= n_hash;
        end
    end

endmodule

// ===== hdl/kmer_minhash_sketch_top.sv =====
// ============================================================================
// kmer_minhash_sketch_top
// MinHash sketch of canonical k-mers, with read and clear commands.
// ============================================================================
// A read registers the store entry, waits until the output register is free,
// then loads the output word. A base with a complete k-mer runs four mixer
// rounds of three partial products on one shared 32x32 multiplier, plus load
// and a bucket update (S_UPD, then S_WR); other bases only load. A clear
// sweeps all 4096 store entries, one entry per cycle. Reset is synchronous,
// active low, and is followed by the same sweep with the input held off.
module kmer_minhash_sketch_top
    import kms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cmd[1:0], base_char[9:2], bucket_index[21:10]
    input  logic        s_axis_tuser,  // seq_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // bucket_value[16:0], empty_count[29:17]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    logic [4:0] r_kmer_len;
    logic [3:0] r_log_buckets;
    logic [4:0] r_fp_bits;
    logic [2:0] r_lz_bits;
    logic       r_ovalid;
    logic [31:0] r_odata;
    logic       busy, out_load, in_fire;
    t_cmd       cmd;
    t_stat      stat;
    logic [16:0] bval;
    logic [EMW-1:0] ecnt;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len    <= 5'd31;
            r_log_buckets <= 4'd10;
            r_fp_bits     <= 5'd8;
            r_lz_bits     <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KMER_LEN:    r_kmer_len    <= i_cfg_data;
                REG_LOG_BUCKETS: r_log_buckets <= i_cfg_data[3:0];
                REG_FP_BITS:     r_fp_bits     <= i_cfg_data;
                REG_LZ_BITS:     r_lz_bits     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    kms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_in_cmd   (s_axis_tdata[1:0]),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_out_load (out_load),
        .i_out_free (!r_ovalid || m_axis_tready),
        .o_cmd      (cmd)
    );

    kms_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_base_char    (s_axis_tdata[9:2]),
        .i_seq_start    (s_axis_tuser),
        .i_bucket_index (s_axis_tdata[21:10]),
        .i_kmer_len     (r_kmer_len),
        .i_log_buckets  (r_log_buckets),
        .i_fp_bits      (r_fp_bits),
        .i_lz_bits      (r_lz_bits),
        .o_bucket_value (bval),
        .o_empty_count  (ecnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_odata <= {2'b0, ecnt, bval};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== hdl/kms_checker.sv =====
// ============================================================================
// kms_checker
// Port-level checks of the sketch top level.
// ============================================================================
module kms_checker
    import kms_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A read command holds the input off in the cycle after it is accepted.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_READ)
        |=> !s_axis_tready) else $error("read did not hold input");

    // A clear holds the input off while the store is swept.
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_CLEAR)
        |=> !s_axis_tready) else $error("clear did not hold input");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16] == 1'b0 || m_axis_tdata[15:0] == 16'hFFFF))
        else $error("bucket value out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind kmer_minhash_sketch_top kms_checker u_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the k-mer MinHash sketch against a cycle-free software copy of its
// behavior. Bases, reads, clears and unused commands are streamed under random
// stalls on both sides. Every read result is compared with the predicted
// bucket value and empty-bucket count.
// ============================================================================
module tb_top;
    import kms_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [12:0] empties;
        logic [16:0] value;
    } t_read_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // cmd[1:0], base_char[9:2], bucket_index[21:10]
    logic        s_axis_tuser;   // seq_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // bucket_value[16:0], empty_count[29:17]
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;

    kmer_minhash_sketch_top dut (.*);

    // Shadow copy of the sketch state and its registers.
    logic [4:0]  kmer_len_r;
    logic [3:0]  log_buckets_r;
    logic [4:0]  fp_bits_r;
    logic [2:0]  lz_bits_r;
    logic [15:0] sk_fp [DEPTH];
    bit          sk_full [DEPTH];
    logic [63:0] fwd_kmer, rc_kmer;
    int unsigned bases_seen, empties;
    int          filled_idx[$];

    t_read_word  pending_reads[$];
    int          n_errors, n_reads, n_bases, n_words;
    longint      cycles;
    bit          calm;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    function automatic int unsigned eff_log();
        return (log_buckets_r > LOG_DEPTH) ? LOG_DEPTH : log_buckets_r;
    endfunction

    function automatic logic [63:0] mix64(logic [63:0] x, logic [63:0] c);
        x = ((x >> 32) ^ x) * c;
        x = ((x >> 32) ^ x) * c;
        return (x >> 32) ^ x;
    endfunction

    function automatic int unsigned lead_zero_count(logic [63:0] h);
        int unsigned n;
        n = 0;
        while (n < 64 && !h[63 - n]) n++;
        return n;
    endfunction

    function automatic logic [15:0] fingerprint_of(logic [63:0] h);
        int unsigned w, hz, m, maxrem, lz, rem;
        logic [31:0] low;
        w      = (fp_bits_r > MAX_FP_WIDTH) ? MAX_FP_WIDTH : fp_bits_r;
        hz     = (lz_bits_r > w) ? w : lz_bits_r;
        m      = w - hz;
        low    = h[31:0] & ((32'd1 << m) - 1);
        maxrem = (1 << hz) - 1;
        lz     = lead_zero_count(h);
        rem    = (maxrem > lz) ? maxrem - lz : 0;
        return 16'(low + (rem << m));
    endfunction

    task automatic clear_shadow();
        for (int i = 0; i < DEPTH; i++) begin
            sk_full[i] = 0;
            sk_fp[i]   = '0;
        end
        filled_idx.delete();
        empties = 1 << eff_log();
    endtask

    task automatic absorb_base(logic [7:0] ch, bit start);
        int unsigned k, lb, bkt;
        logic [63:0] mask, fcode, rcode, canon, hb;
        logic [15:0] fp;
        k     = (kmer_len_r < 2) ? 2 : kmer_len_r;
        mask  = (64'd1 << (2 * k)) - 1;
        fcode = (ch == "C") ? 1 : (ch == "G") ? 2 : (ch == "T") ? 3 : 0;
        rcode = (ch == "A") ? 3 : (ch == "C") ? 2 : (ch == "G") ? 1 : 0;
        if (start) begin
            fwd_kmer = '0;
            rc_kmer = '0;
            bases_seen = 0;
        end
        fwd_kmer = ((fwd_kmer << 2) | fcode) & mask;
        rc_kmer  = ((rc_kmer & mask) >> 2) | (rcode << (2 * k - 2));
        if (bases_seen < 31) bases_seen++;
        if (bases_seen < k) return;
        n_bases++;
        canon = (fwd_kmer < rc_kmer) ? fwd_kmer : rc_kmer;
        lb = eff_log();
        hb = mix64(canon, MIX_INV);
        bkt = (lb == 0) ? 0 : int'(hb >> (64 - lb));
        bkt = bkt & (DEPTH - 1);
        fp = fingerprint_of(mix64(canon, MIX_FWD));
        if (!sk_full[bkt]) begin
            sk_full[bkt] = 1;
            sk_fp[bkt] = fp;
            filled_idx = {filled_idx, int'(bkt)};
            if (empties > 0) empties--;
        end else if (sk_fp[bkt] > fp) begin
            sk_fp[bkt] = fp;
        end
    endtask

    task automatic predict_word(logic [1:0] cmd, logic [7:0] ch, bit start,
                                logic [11:0] idx);
        t_read_word r;
        case (cmd)
            CMD_BASE: begin
                absorb_base(ch, start);
            end
            CMD_CLEAR: begin
                clear_shadow();
            end
            CMD_READ: begin
                r.value   = sk_full[idx] ? {1'b0, sk_fp[idx]} : 17'h1FFFF;
                r.empties = 13'(empties);
                pending_reads = {pending_reads, r};
            end
            default: ;
        endcase
    endtask

    // Sends one word, with a random gap first unless the stream is calm.
    task automatic send_word(logic [1:0] cmd, logic [7:0] ch, bit start,
                             logic [11:0] idx);
        int gap;
        gap = (!calm && $urandom_range(99) < 38) ? $urandom_range(4, 1) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, ch, cmd};
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        n_words++;
        predict_word(cmd, ch, start, idx);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        // A hashed base or a clearing sweep may still be running; wait until
        // the block takes input again.
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_KMER_LEN:    kmer_len_r    = val;
            REG_LOG_BUCKETS: log_buckets_r = val[3:0];
            REG_FP_BITS:     fp_bits_r     = val;
            REG_LZ_BITS:     lz_bits_r     = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int k, int lb, int fp, int lz);
        drain();
        write_reg(REG_KMER_LEN, 5'(k));
        write_reg(REG_LOG_BUCKETS, 5'(lb));
        write_reg(REG_FP_BITS, 5'(fp));
        write_reg(REG_LZ_BITS, 5'(lz));
    endtask

    function automatic logic [7:0] pick_base();
        case ($urandom_range(3))
            0: return "A";
            1: return "C";
            2: return "G";
            default: return "T";
        endcase
    endfunction

    function automatic logic [11:0] pick_bucket();
        if (filled_idx.size() != 0 && $urandom_range(1))
            return 12'(filled_idx[$urandom_range(filled_idx.size() - 1)]);
        if ($urandom_range(3) == 0) return 12'($urandom_range(DEPTH - 1));
        return 12'($urandom_range((1 << eff_log()) - 1));
    endfunction

    task automatic read_some(int n);
        repeat (n) send_word(CMD_READ, 8'($urandom), $urandom_range(1), pick_bucket());
    endtask

    task automatic test_reset_state();
        send_word(CMD_READ, 8'h00, 1'b0, 12'h000);
        send_word(CMD_READ, 8'hFF, 1'b1, 12'hFFF);
    endtask

    // Odd characters, start flags, unused command and clear with small k.
    task automatic test_directed();
        set_regs(2, 4, 8, 4);
        send_word(CMD_BASE, "A", 1'b1, 12'h000);
        send_word(CMD_BASE, "C", 1'b0, 12'hFFF);
        send_word(CMD_BASE, "G", 1'b0, 12'h000);
        send_word(CMD_BASE, "T", 1'b0, 12'h000);
        send_word(CMD_BASE, "N", 1'b0, 12'h000);
        send_word(CMD_BASE, 8'h00, 1'b0, 12'h000);
        send_word(CMD_BASE, 8'hFF, 1'b0, 12'h000);
        send_word(CMD_BASE, "a", 1'b1, 12'h000);
        send_word(CMD_BASE, "G", 1'b1, 12'h000);
        send_word(CMD_BASE, "G", 1'b0, 12'h000);
        send_word(CMD_UNUSED, 8'hFF, 1'b1, 12'hFFF);
        read_some(4);
        send_word(CMD_CLEAR, 8'hFF, 1'b1, 12'hFFF);
        read_some(2);
        send_word(CMD_BASE, "T", 1'b0, 12'h000);
        send_word(CMD_BASE, "A", 1'b0, 12'h000);
        read_some(2);
    endtask

    // Out-of-range and extreme register settings.
    task automatic test_register_extremes();
        int cfg[6][4] = '{'{0, 0, 2, 1}, '{1, 15, 31, 7}, '{31, 12, 16, 6},
                          '{3, 1, 17, 0}, '{5, 13, 16, 1}, '{2, 12, 2, 6}};
        for (int c = 0; c < 6; c++) begin
            set_regs(cfg[c][0], cfg[c][1], cfg[c][2], cfg[c][3]);
            if (c != 3) send_word(CMD_CLEAR, 8'h00, 1'b0, 12'h000);
            for (int i = 0; i < 40; i++)
                send_word(CMD_BASE, pick_base(), i == 0, 12'($urandom));
            read_some(6);
        end
    endtask

    // Mostly clean sequences with random content, plus noise and stray commands.
    task automatic test_random(int total);
        int sent, len, r;
        sent = 0;
        while (sent < total) begin
            calm = (sent < 300);
            if (sent % 300 == 299) begin
                calm = 0;
                set_regs($urandom_range(31), $urandom_range(15),
                         $urandom_range(31), $urandom_range(7));
            end
            r = $urandom_range(99);
            if (r < 70) begin
                len = $urandom_range(40, 1);
                for (int i = 0; i < len; i++)
                    send_word(CMD_BASE,
                              ($urandom_range(19) == 0) ? 8'($urandom) : pick_base(),
                              i == 0, 12'($urandom));
                sent += len;
            end else if (r < 92) begin
                read_some(1);
                sent++;
            end else if (r < 95) begin
                send_word(CMD_CLEAR, 8'($urandom), $urandom_range(1), 12'($urandom));
                sent++;
            end else begin
                send_word(CMD_UNUSED, 8'($urandom), $urandom_range(1), 12'($urandom));
                sent++;
            end
        end
        calm = 0;
        read_some(8);
    endtask

    always @(posedge i_clk) begin
        t_read_word got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_read_word'(m_axis_tdata[29:0]);
            n_reads++;
            if (pending_reads.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected read word: value %h empties %0d",
                             got.value, got.empties);
            end else begin
                want = pending_reads.pop_front();
                if (got.value !== want.value || got.empties !== want.empties) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("read mismatch: value %h/%h empties %0d/%0d (exp/got)",
                                 want.value, got.value, want.empties, got.empties);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        n_errors = 0;
        n_reads = 0;
        n_bases = 0;
        n_words = 0;
        calm = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        kmer_len_r = 5'd31;
        log_buckets_r = 4'd10;
        fp_bits_r = 5'd8;
        lz_bits_r = 3'd4;
        fwd_kmer = '0;
        rc_kmer = '0;
        bases_seen = 0;
        clear_shadow();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_register_extremes();
        set_regs(4, 6, 10, 3);
        send_word(CMD_CLEAR, 8'h00, 1'b0, 12'h000);
        test_random(900);
        drain();

        $display("covered %0d words, %0d hashed k-mers, %0d read results",
                 n_words, n_bases, n_reads);
        $display("mismatches: %0d, reads still awaited: %0d",
                 n_errors, pending_reads.size());
        if (n_errors == 0 && pending_reads.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
